// File: hw/rtl/b64sd_pkg.sv
package b64sd_pkg;

   // Queue between front and back; the depth must be a power of two.
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic [7:0] PAD_CHAR  = 8'h3D;
   localparam logic [6:0] NO_SEXTET = 7'd64;

   // Byte places within a decoded group.
   localparam logic [1:0] BYTE_HI  = 2'd0;
   localparam logic [1:0] BYTE_MID = 2'd1;
   localparam logic [1:0] BYTE_LO  = 2'd2;

   // One group's worth of work for the back end.
   typedef struct packed {
      logic [23:0] value;   // four sextets, first one highest
      logic [1:0]  count;   // bytes to emit, 1 to 3
      logic        fin;     // group closes the message
      logic        err;     // emit a single error result instead
   } b64sd_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } b64sd_qstat_type;

   // Sextet value of a character, or NO_SEXTET outside the alphabet.
   function automatic logic [6:0] sextet_of(input logic [7:0] c);
      logic [6:0] r;
      r = NO_SEXTET;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = 7'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         r = 7'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r = 7'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         r = 7'd62;
      end else if (c == 8'h2F) begin
         r = 7'd63;
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/b64sd_front.sv
module b64sd_front import b64sd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic [7:0]    char_code,
   input  logic          final_char,
   output logic          push_valid,
   output b64sd_cmd_type push_cmd
);

   logic [1:0]  pos_ff, pos_in;
   logic [17:0] sext_ff, sext_in;
   logic        tp_ff, tp_in;
   logic        bad_ff, bad_in;
   logic        discard_ff, discard_in;

   logic [6:0]  code;
   logic        valid_c;
   logic        pad;
   logic [5:0]  sx;
   logic        bad_v;
   logic        tp_v;
   logic [17:0] sext_v;

   assign code    = sextet_of(char_code);
   assign valid_c = !code[6];
   assign pad     = (char_code == PAD_CHAR);
   assign sx      = valid_c ? code[5:0] : 6'd0;

   always_comb begin
      pos_in     = pos_ff;
      sext_in    = sext_ff;
      tp_in      = tp_ff;
      bad_in     = bad_ff;
      discard_in = discard_ff;
      push_valid = 1'b0;
      push_cmd   = '0;
      bad_v      = bad_ff;
      tp_v       = tp_ff;
      sext_v     = sext_ff;

      unique case (pos_ff)
         2'd0: begin
            bad_v  = bad_ff | !valid_c;
            sext_v = {sx, 12'd0};
            tp_v   = 1'b0;
         end
         2'd1: begin
            bad_v  = bad_ff | !valid_c;
            sext_v = {sext_ff[17:12], sx, 6'd0};
         end
         2'd2: begin
            if (pad) begin
               tp_v = 1'b1;
            end else begin
               bad_v = bad_ff | !valid_c;
            end
            sext_v = {sext_ff[17:6], sx};
         end
         default: begin
            if (pad) begin
               bad_v = bad_ff | !final_char;
            end else begin
               bad_v = bad_ff | !valid_c | tp_ff;
            end
         end
      endcase

      if (accept) begin
         if (discard_ff) begin
            // Swallow everything up to and including the final character.
            if (final_char) begin
               discard_in = 1'b0;
               pos_in     = 2'd0;
               sext_in    = '0;
               tp_in      = 1'b0;
               bad_in     = 1'b0;
            end
         end else if (pos_ff != 2'd3 && !final_char) begin
            pos_in  = 2'(pos_ff + 2'd1);
            sext_in = sext_v;
            tp_in   = tp_v;
            bad_in  = bad_v;
         end else begin
            push_valid     = 1'b1;
            push_cmd.err   = (pos_ff != 2'd3) || bad_v;
            push_cmd.value = {sext_v, sx};
            push_cmd.count = 2'd1 + {1'b0, !tp_ff} + {1'b0, !pad};
            push_cmd.fin   = final_char;
            discard_in     = push_cmd.err && !final_char;
            pos_in         = 2'd0;
            sext_in        = '0;
            tp_in          = 1'b0;
            bad_in         = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= 2'd0;
         sext_ff    <= '0;
         tp_ff      <= 1'b0;
         bad_ff     <= 1'b0;
         discard_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         sext_ff    <= sext_in;
         tp_ff      <= tp_in;
         bad_ff     <= bad_in;
         discard_ff <= discard_in;
      end
   end

endmodule

// File: hw/rtl/b64sd_queue.sv
module b64sd_queue import b64sd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  b64sd_cmd_type   push_cmd,
   input  logic            pop,
   output b64sd_cmd_type   head_cmd,
   output b64sd_qstat_type status
);

   b64sd_cmd_type      mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ff, wr_in;
   logic [Q_PTR_W-1:0] rd_ff, rd_in;
   logic [Q_CNT_W-1:0] cnt_ff, cnt_in;
   logic               do_push;
   logic               do_pop;

   assign status.full  = (cnt_ff == Q_CNT_W'(Q_DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_cmd     = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? Q_PTR_W'(wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop ? Q_PTR_W'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = Q_CNT_W'(cnt_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         cnt_in = Q_CNT_W'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: hw/rtl/b64sd_back.sv
module b64sd_back import b64sd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  b64sd_cmd_type   head_cmd,
   input  b64sd_qstat_type status,
   output logic            pop,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [7:0]      rsp_tdata,
   output logic            rsp_tlast,
   output logic [1:0]      rsp_tuser
);

   logic [1:0] idx_ff, idx_in;
   logic       ovalid_ff, ovalid_in;
   logic [7:0] odata_ff, odata_in;
   logic       olast_ff, olast_in;
   logic       orun_ff, orun_in;
   logic       obad_ff, obad_in;
   logic       load;
   logic       last_byte;
   logic [7:0] byte_sel;

   // The output register takes a new item whenever it is empty or being drained.
   assign load      = !status.empty && (!ovalid_ff || rsp_tready);
   assign last_byte = (idx_ff == 2'(head_cmd.count - 2'd1));

   always_comb begin
      unique case (idx_ff)
         BYTE_HI:  byte_sel = head_cmd.value[23:16];
         BYTE_MID: byte_sel = head_cmd.value[15:8];
         BYTE_LO:  byte_sel = head_cmd.value[7:0];
         default:  byte_sel = 8'd0;
      endcase
   end

   always_comb begin
      idx_in    = idx_ff;
      ovalid_in = ovalid_ff && !rsp_tready;
      odata_in  = odata_ff;
      olast_in  = olast_ff;
      orun_in   = orun_ff;
      obad_in   = obad_ff;
      pop       = 1'b0;
      if (load) begin
         ovalid_in = 1'b1;
         if (head_cmd.err) begin
            odata_in = 8'd0;
            olast_in = 1'b1;
            orun_in  = 1'b1;
            obad_in  = 1'b1;
            pop      = 1'b1;
            idx_in   = 2'd0;
         end else begin
            odata_in = byte_sel;
            orun_in  = last_byte;
            olast_in = last_byte && head_cmd.fin;
            obad_in  = 1'b0;
            pop      = last_byte;
            idx_in   = last_byte ? 2'd0 : 2'(idx_ff + 2'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= 2'd0;
         ovalid_ff <= 1'b0;
      end else begin
         idx_ff    <= idx_in;
         ovalid_ff <= ovalid_in;
      end
      odata_ff <= odata_in;
      olast_ff <= olast_in;
      orun_ff  <= orun_in;
      obad_ff  <= obad_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tuser  = {obad_ff, orun_ff};

endmodule

// File: hw/rtl/base64_strict_decoder.sv
// Channel  | Direction | Payload
// req_*    | in        | tdata = char_code, tlast = final_char
// rsp_*    | out       | tdata = data_byte, tlast = message_end, tuser = run_last, invalid
//
// One character is accepted per cycle while the four-entry group queue has room.
// A group's closing character pushes it into the queue, from whose head its results move to
// the output register; they follow one per cycle from there while rsp_tready is high.
// Reset is synchronous and clears the group state, the queue and the output.
// A stalled result fills the queue; req_tready falls only when it is full.
module base64_strict_decoder import b64sd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] data_byte
   output logic       rsp_tlast,
   output logic [1:0] rsp_tuser    // [0] run_last, [1] invalid
);

   b64sd_cmd_type   push_cmd;
   b64sd_cmd_type   head_cmd;
   b64sd_qstat_type status;
   logic            push_valid;
   logic            pop;
   logic            accept;

   assign req_tready = !status.full;
   assign accept     = req_tvalid && req_tready;

   b64sd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .char_code  (req_tdata),
      .final_char (req_tlast),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   b64sd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (status)
   );

   b64sd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .status     (status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !status.full)
      else $error("group pushed into a full queue");

   a_error_item_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast && rsp_tuser[0] && rsp_tdata == 8'd0)
      else $error("error item is not a closing zero item");

   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[0])
      else $error("message end on an item that is not last of its run");

   a_pop_only_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("queue popped while empty");

endmodule

// File: sim/b64sd_checker.sv
module b64sd_checker import b64sd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] char_code
   input  logic       req_tlast,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,    // [7:0] data_byte
   input  logic       rsp_tlast,
   input  logic [1:0] rsp_tuser,    // [0] run_last, [1] invalid
   output int         fail_count,
   output int         bytes_pending,
   output int         chars_decoded
);

   typedef struct packed {
      logic [7:0] data;
      logic       run_last;
      logic       msg_end;
      logic       invalid;
   } decoded_byte_type;

   decoded_byte_type due_bytes[$];

   logic [1:0]  grp_pos;
   logic [17:0] grp_sextets;
   logic        grp_third_pad;
   logic        grp_bad;
   logic        swallowing;

   initial begin
      fail_count    = 0;
      bytes_pending = 0;
      chars_decoded = 0;
      grp_pos       = 2'd0;
      grp_sextets   = 18'd0;
      grp_third_pad = 1'b0;
      grp_bad       = 1'b0;
      swallowing    = 1'b0;
   end

   function automatic logic [6:0] char_sextet(input logic [7:0] c);
      if (c >= "A" && c <= "Z") return 7'(c - "A");
      if (c >= "a" && c <= "z") return 7'(c - "a") + 7'd26;
      if (c >= "0" && c <= "9") return 7'(c - "0") + 7'd52;
      if (c == "+") return 7'd62;
      if (c == "/") return 7'd63;
      return NO_SEXTET;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      fail_count++;
      if (fail_count <= 40) begin
         $display("mismatch at %0t: %s, got %0h, expected %0h", $realtime, what, got, want);
      end
   endtask

   task automatic clear_group();
      grp_pos       = 2'd0;
      grp_sextets   = 18'd0;
      grp_third_pad = 1'b0;
      grp_bad       = 1'b0;
   endtask

   task automatic push_byte(input logic [7:0] data, input logic last, input logic fin,
                            input logic bad);
      decoded_byte_type r;
      r.data     = data;
      r.run_last = last;
      r.msg_end  = fin;
      r.invalid  = bad;
      due_bytes = {due_bytes, r};
   endtask

   task automatic take_char(input logic [7:0] c, input logic fin);
      logic [6:0]  code;
      logic        ok;
      logic        pad;
      logic        bad;
      logic [5:0]  sx;
      logic [23:0] word;
      int          nbytes;
      code = char_sextet(c);
      ok   = (code != NO_SEXTET);
      pad  = (c == PAD_CHAR);
      bad  = grp_bad;
      sx   = ok ? code[5:0] : 6'd0;
      // After an error everything up to the flagged end of the message is dropped.
      if (swallowing) begin
         if (fin) begin
            swallowing = 1'b0;
            clear_group();
         end
         return;
      end
      chars_decoded++;
      case (grp_pos)
         2'd0: begin
            bad |= !ok;
            grp_sextets   = {sx, 12'd0};
            grp_third_pad = 1'b0;
         end
         2'd1: begin
            bad |= !ok;
            grp_sextets[11:6] = sx;
         end
         2'd2: begin
            if (pad) grp_third_pad = 1'b1;
            else bad |= !ok;
            grp_sextets[5:0] = sx;
         end
         default: begin
            if (pad) bad |= !fin;
            else bad |= !ok | grp_third_pad;
         end
      endcase
      if (grp_pos != 2'd3 && !fin) begin
         grp_bad = bad;
         grp_pos = grp_pos + 2'd1;
         return;
      end
      if (grp_pos != 2'd3 || bad) begin
         push_byte(8'd0, 1'b1, 1'b1, 1'b1);
         clear_group();
         swallowing = !fin;
         return;
      end
      word   = {grp_sextets, sx};
      nbytes = 1 + (grp_third_pad ? 0 : 1) + (pad ? 0 : 1);
      for (int k = 0; k < nbytes; k++) begin
         push_byte(word[23 - 8 * k -: 8], k == nbytes - 1, (k == nbytes - 1) && fin, 1'b0);
      end
      clear_group();
   endtask

   always @(posedge clock) begin
      decoded_byte_type want;
      if (reset) begin
         due_bytes.delete();
         clear_group();
         swallowing = 1'b0;
      end else begin
         if (req_tvalid && req_tready) take_char(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (due_bytes.size() == 0) begin
               report_mismatch("item with nothing expected", rsp_tdata, 0);
            end else begin
               want = due_bytes.pop_front();
               if (rsp_tdata !== want.data)
                  report_mismatch("data_byte", rsp_tdata, want.data);
               if (rsp_tuser[0] !== want.run_last)
                  report_mismatch("run_last", rsp_tuser[0], want.run_last);
               if (rsp_tlast !== want.msg_end)
                  report_mismatch("message_end", rsp_tlast, want.msg_end);
               if (rsp_tuser[1] !== want.invalid)
                  report_mismatch("invalid", rsp_tuser[1], want.invalid);
            end
         end
      end
      bytes_pending = due_bytes.size();
   end

endmodule

// File: sim/tb.sv
module tb import b64sd_pkg::*; ();

   localparam int CYCLE_LIMIT  = 200000;
   localparam int ITEM_TARGET  = 215;
   localparam int CALM_FROM    = 180;
   localparam int PAUSE_AT     = 110;

   typedef enum {
      MSG_CLEAN, MSG_TWO_PART, MSG_BAD_CHAR, MSG_STRAY_PAD, MSG_BAD_LENGTH, MSG_NOISE
   } msg_kind_type;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic [1:0] rsp_tuser;

   int fail_count;
   int bytes_pending;
   int chars_decoded;
   int cycles;
   int gap_rate;
   bit calm;

   logic [7:0] text[$];

   base64_strict_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   b64sd_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .bytes_pending (bytes_pending),
      .chars_decoded (chars_decoded)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("base64_strict_decoder verification failed");
         $finish;
      end
   end

   // The consumer stalls in bursts, with quiet stretches between them.
   initial begin
      int  hold;
      bit  stall_on;
      logic next_ready;
      hold       = 0;
      stall_on   = 1'b1;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 49) == 0) stall_on = !stall_on;
         if (hold > 0) begin
            hold--;
            next_ready = 1'b0;
         end else if (!calm && stall_on && $urandom_range(0, 4) == 0) begin
            hold       = $urandom_range(1, 6) - 1;
            next_ready = 1'b0;
         end else begin
            next_ready = 1'b1;
         end
         rsp_tready <= next_ready;
      end
   end

   function automatic logic [7:0] sextet_char(input logic [5:0] s);
      if (s < 6'd26) return 8'("A" + s);
      if (s < 6'd52) return 8'("a" + (s - 6'd26));
      if (s < 6'd62) return 8'("0" + (s - 6'd52));
      return (s == 6'd62) ? 8'("+") : 8'("/");
   endfunction

   task automatic add_char(input logic [7:0] c);
      text = {text, c};
   endtask

   // Appends the encoding of n random bytes, padded to whole groups.
   task automatic append_encoded(input int n);
      logic [23:0] word;
      int          cnt;
      for (int i = 0; i < n; i += 3) begin
         cnt  = (n - i < 3) ? n - i : 3;
         word = {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255))};
         if (cnt < 3) word[7:0] = 8'd0;
         if (cnt < 2) word[15:8] = 8'd0;
         add_char(sextet_char(word[23:18]));
         add_char(sextet_char(word[17:12]));
         add_char(cnt >= 2 ? sextet_char(word[11:6]) : PAD_CHAR);
         add_char(cnt == 3 ? sextet_char(word[5:0]) : PAD_CHAR);
      end
   endtask

   task automatic load(input string s);
      text.delete();
      for (int i = 0; i < s.len(); i++) add_char(s[i]);
   endtask

   task automatic send_char(input logic [7:0] c, input logic fin);
      if (gap_rate != 0 && !calm && $urandom_range(0, 5) < gap_rate) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_text();
      for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (bytes_pending != 0) @(negedge clock);
   endtask

   initial begin
      msg_kind_type kind;
      int           pick;
      int           idx;
      bit           paused;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'd0;
      req_tlast  = 1'b0;
      calm       = 1'b0;
      gap_rate   = 2;
      paused     = 1'b0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: extreme values, both padding forms and the strict-rule violations.
      load("////");
      send_text();
      load("AA==");
      send_text();
      load("+/8=");
      send_text();
      text = '{8'h00, PAD_CHAR, 8'h41, 8'hFF};
      send_text();
      load("AB=C");
      send_text();
      load("AB");
      send_text();
      // Padding in a group that does not end the message, then the rest is swallowed.
      load("AA==Q");
      send_text();
      drain();

      while (chars_decoded < ITEM_TARGET) begin
         gap_rate = $urandom_range(0, 3);
         pick     = $urandom_range(0, 15);
         if (pick < 7) kind = MSG_CLEAN;
         else if (pick < 9) kind = MSG_TWO_PART;
         else if (pick < 11) kind = MSG_BAD_CHAR;
         else if (pick < 13) kind = MSG_STRAY_PAD;
         else if (pick < 15) kind = MSG_BAD_LENGTH;
         else kind = MSG_NOISE;
         text.delete();
         append_encoded($urandom_range(1, 9));
         case (kind)
            MSG_TWO_PART: append_encoded($urandom_range(1, 6));
            MSG_BAD_CHAR: begin
               idx       = $urandom_range(0, text.size() - 1);
               text[idx] = 8'($urandom_range(0, 255));
            end
            MSG_STRAY_PAD: begin
               idx       = $urandom_range(0, text.size() - 1);
               text[idx] = PAD_CHAR;
            end
            MSG_BAD_LENGTH: begin
               if ($urandom_range(0, 1) == 0) begin
                  repeat ($urandom_range(1, 3)) void'(text.pop_back());
               end else begin
                  repeat ($urandom_range(1, 3))
                     add_char(sextet_char(6'($urandom_range(0, 63))));
               end
            end
            MSG_NOISE: begin
               text.delete();
               repeat ($urandom_range(1, 8)) add_char(8'($urandom_range(0, 255)));
            end
            default: ;
         endcase
         send_text();
         if (!paused && chars_decoded >= PAUSE_AT) begin
            drain();
            paused = 1'b1;
         end
         if (chars_decoded >= CALM_FROM) calm = 1'b1;
      end

      drain();
      repeat (8) @(negedge clock);
      if (fail_count == 0) begin
         $display("base64_strict_decoder verification clean");
      end else begin
         $display("base64_strict_decoder verification failed");
      end
      $finish;
   end

endmodule

// File: files.f
hw/rtl/b64sd_pkg.sv
hw/rtl/b64sd_front.sv
hw/rtl/b64sd_queue.sv
hw/rtl/b64sd_back.sv
hw/rtl/base64_strict_decoder.sv
sim/b64sd_checker.sv
sim/tb.sv
